>>> src/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Op codes, register indexes and rule constants of the life cell grid.
// ----------------------------------------------------------------------------
package lca_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_cfg_index;

    localparam t_op OP_WRITE   = 2'd0;
    localparam t_op OP_ADVANCE = 2'd1;
    localparam t_op OP_READ    = 2'd2;
    localparam t_op OP_NONE    = 2'd3;

    localparam t_cfg_index CFG_GRID_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_GRID_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_WRAP_EDGES  = 2'd2;

    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned COORD_W    = 6;
    localparam int unsigned GEN_W      = 16;

    localparam int unsigned SIZE_RESET = 64;

    // B3/S23: born on three, dies at one or fewer and at four or more
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] LONELY_MAX  = 4'd1;
    localparam logic [3:0] CROWD_MIN   = 4'd4;

endpackage

>>> src/life_cellular_automaton.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton
// B3/S23 cell grid held as one row memory; advance streams a three-row
// window over the rows and writes each new row back in place.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | to block  | i_in_valid / o_in_stall   | op, col, row, value, gens
//  out      | from blk  | o_out_valid / i_out_stall | alive, out_of_range
//  cfg      | to block  | i_cfg_valid / o_cfg_ready | index, data
//
//  write / read cell: row read, modify or pick, result, output
//  out of range coordinate or unused op: no row read, straight to the result
//  advance: each generation streams all rows through the single row read port;
//  stops early once a generation changes nothing
//  reset clears the per-row valid bits, no clearing pass
//  a result waiting on i_out_stall does not stop the next input transfer
// ----------------------------------------------------------------------------
module life_cellular_automaton #(
    parameter int unsigned MAX_WIDTH  = 64,
    parameter int unsigned MAX_HEIGHT = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  lca_pkg::t_cfg_index                      i_cfg_index,
    input  logic [lca_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  lca_pkg::t_op                             i_op,
    input  logic [lca_pkg::COORD_W-1:0]              i_col,
    input  logic [lca_pkg::COORD_W-1:0]              i_row,
    input  logic                                     i_cell_value,
    input  logic [lca_pkg::GEN_W-1:0]                i_generations,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic                                     o_alive,
    output logic                                     o_out_of_range
);
    import lca_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned AW = $clog2(MAX_HEIGHT);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned TW = $clog2(MAX_HEIGHT + 2);
    localparam int unsigned CMPW = (WW > HW ? WW : HW) + CFG_DATA_W;
    localparam int unsigned W_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
    localparam int unsigned H_RESET = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CELL_RD = 3'd1;
    localparam logic [2:0] S_CELL_WR = 3'd2;
    localparam logic [2:0] S_GEN     = 3'd3;
    localparam logic [2:0] S_WAIT    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    typedef logic [MAX_WIDTH-1:0] t_row;

    // row memory and per-row valid bits
    t_row                r_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] r_row_valid;
    t_row                r_rdata;
    logic                r_rvalid;

    logic [2:0]          r_state;
    logic [WW-1:0]       r_w;
    logic [HW-1:0]       r_h;
    logic                r_wrap;

    t_op                 r_op;
    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  r_row;
    logic                r_value;
    logic [GEN_W-1:0]    r_gen_left;

    logic [TW-1:0]       r_k;
    logic                r_dv;
    logic [TW-1:0]       r_dt;
    logic                r_cv;
    logic [AW-1:0]       r_cy;
    logic                r_changed;
    t_row                r_a;
    t_row                r_m;
    t_row                r_b;
    t_row                r_first;

    logic                r_res_alive;
    logic                r_res_oor;
    logic                r_o_valid;
    logic                r_o_alive;
    logic                r_o_oor;

    logic [AW-1:0]       raddr;
    logic                we;
    logic [AW-1:0]       waddr;
    t_row                wdata;
    t_row                rd_raw;
    t_row                d_eff;
    t_row                wmask;
    logic [CW-1:0]       wm1;
    t_row                am, mm, bm;
    t_row                next_row;
    t_row                gen_row;
    logic                row_chg;
    logic                gen_end;
    logic                in_xfer;
    logic                in_oor;
    logic                out_free;
    t_row                cell_row;
    logic [AW-1:0]       h_last;

    function automatic t_row shl(input t_row x, input t_row m, input logic [CW-1:0] last,
                                 input logic wrap);
        logic [MAX_WIDTH+1:0] xp;
        t_row                 res;
        xp = {1'b0, x, 1'b0};
        for (int c = 0; c < MAX_WIDTH; c++) begin
            res[c] = (c == 0) ? (wrap & x[last]) : xp[c];
        end
        return res & m;
    endfunction

    function automatic t_row shr(input t_row x, input t_row m, input logic [CW-1:0] last,
                                 input logic wrap);
        logic [MAX_WIDTH+1:0] xp;
        t_row                 res;
        xp = {1'b0, x, 1'b0};
        for (int c = 0; c < MAX_WIDTH; c++) begin
            res[c] = (CW'(c) == last) ? (wrap & x[0]) : xp[c + 2];
        end
        return res & m;
    endfunction

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_alive        = r_o_alive;
    assign o_out_of_range = r_o_oor;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_o_valid || !i_out_stall;
    assign in_oor   = (CMPW'(i_col) >= CMPW'(r_w)) || (CMPW'(i_row) >= CMPW'(r_h));
    assign h_last   = AW'(r_h - HW'(1));
    assign wm1      = CW'(r_w - WW'(1));
    assign rd_raw   = r_rvalid ? r_rdata : '0;

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            wmask[c] = (WW'(c) < r_w);
        end
    end

    // read address
    always_comb begin
        raddr = '0;
        if (r_state == S_GEN) begin
            if (r_k == '0) begin
                raddr = h_last;
            end else if (r_k > TW'(r_h)) begin
                raddr = '0;
            end else begin
                raddr = AW'(r_k - TW'(1));
            end
        end else if (r_state == S_CELL_RD) begin
            raddr = AW'(r_row);
        end
    end

    // data entering the window: top neighbor first, wrap row last
    always_comb begin
        if (r_dt == '0) begin
            d_eff = r_wrap ? rd_raw : '0;
        end else if (r_dt == TW'(r_h) + TW'(1)) begin
            d_eff = r_wrap ? r_first : '0;
        end else begin
            d_eff = rd_raw;
        end
    end

    // next generation of the middle row
    always_comb begin
        t_row al, ar, ml, mr, bl, br;
        logic [3:0] cnt;
        am = r_a & wmask;
        mm = r_m & wmask;
        bm = r_b & wmask;
        al = shl(am, wmask, wm1, r_wrap);
        ar = shr(am, wmask, wm1, r_wrap);
        ml = shl(mm, wmask, wm1, r_wrap);
        mr = shr(mm, wmask, wm1, r_wrap);
        bl = shl(bm, wmask, wm1, r_wrap);
        br = shr(bm, wmask, wm1, r_wrap);
        for (int c = 0; c < MAX_WIDTH; c++) begin
            cnt = 4'(am[c]) + 4'(bm[c]) + 4'(al[c]) + 4'(ar[c])
                + 4'(bl[c]) + 4'(br[c]) + 4'(ml[c]) + 4'(mr[c]);
            next_row[c] = wmask[c] & ((cnt == BIRTH_COUNT)
                        || (mm[c] && cnt > LONELY_MAX && cnt < CROWD_MIN));
        end
        gen_row = (r_m & ~wmask) | next_row;
    end

    assign row_chg = (gen_row != r_m);
    assign gen_end = r_cv && (r_cy == h_last);

    always_comb begin
        cell_row = rd_raw;
        cell_row[CW'(r_col)] = r_value;
    end

    // write port
    always_comb begin
        we    = 1'b0;
        waddr = r_cy;
        wdata = gen_row;
        if (r_cv) begin
            we = 1'b1;
        end else if (r_state == S_CELL_WR && r_op == OP_WRITE) begin
            we    = 1'b1;
            waddr = AW'(r_row);
            wdata = cell_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[raddr];
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rvalid    <= 1'b0;
        end else begin
            r_rvalid <= r_row_valid[raddr];
            if (we) begin
                r_row_valid[waddr] <= 1'b1;
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WW'(W_RESET);
            r_h    <= HW'(H_RESET);
            r_wrap <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_w <= WW'(1);
                    end else if (CMPW'(i_cfg_data) > CMPW'(MAX_WIDTH)) begin
                        r_w <= WW'(MAX_WIDTH);
                    end else begin
                        r_w <= WW'(i_cfg_data);
                    end
                end
                CFG_GRID_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_h <= HW'(1);
                    end else if (CMPW'(i_cfg_data) > CMPW'(MAX_HEIGHT)) begin
                        r_h <= HW'(MAX_HEIGHT);
                    end else begin
                        r_h <= HW'(i_cfg_data);
                    end
                end
                CFG_WRAP_EDGES: begin
                    r_wrap <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // window and captured item fields
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= i_op;
            r_col   <= i_col;
            r_row   <= i_row;
            r_value <= i_cell_value;
        end
        if (r_dv) begin
            r_a <= r_m;
            r_m <= r_b;
            r_b <= d_eff;
            if (r_dt == TW'(1)) begin
                r_first <= rd_raw;
            end
        end
        r_cy <= AW'(r_dt - TW'(2));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_dv        <= 1'b0;
            r_dt        <= '0;
            r_cv        <= 1'b0;
            r_changed   <= 1'b0;
            r_gen_left  <= '0;
            r_res_alive <= 1'b0;
            r_res_oor   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_o_alive   <= 1'b0;
            r_o_oor     <= 1'b0;
        end else begin
            r_dv <= (r_state == S_GEN);
            r_dt <= r_k;
            r_cv <= r_dv && (r_dt >= TW'(2));
            if (r_cv && row_chg && !gen_end) begin
                r_changed <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_alive <= 1'b0;
                        r_res_oor   <= (i_op == OP_WRITE || i_op == OP_READ) && in_oor;
                        priority if (i_op == OP_WRITE || i_op == OP_READ) begin
                            if (in_oor) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_CELL_RD;
                            end
                        end else if (i_op == OP_ADVANCE && i_generations != '0) begin
                            r_gen_left <= i_generations;
                            r_k        <= '0;
                            r_changed  <= 1'b0;
                            r_state    <= S_GEN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CELL_RD: begin
                    r_state <= S_CELL_WR;
                end
                S_CELL_WR: begin
                    if (r_op == OP_READ) begin
                        r_res_alive <= rd_raw[CW'(r_col)];
                    end
                    r_state <= S_DONE;
                end
                S_GEN: begin
                    r_k <= r_k + TW'(1);
                    if (r_k == TW'(r_h) + TW'(1)) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (gen_end) begin
                        if ((r_changed || row_chg) && r_gen_left != GEN_W'(1)) begin
                            r_gen_left <= r_gen_left - GEN_W'(1);
                            r_k        <= '0;
                            r_changed  <= 1'b0;
                            r_state    <= S_GEN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
                r_o_alive <= r_res_alive;
                r_o_oor   <= r_res_oor;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_xfer_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE)
        else $error("input transfer did not start work");

    a_write_only_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (r_state == S_GEN || r_state == S_WAIT))
        else $error("row write-back outside a generation");

    a_row_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> HW'(r_cy) < r_h)
        else $error("row write-back beyond the area in use");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GEN |-> r_k <= TW'(r_h) + TW'(1))
        else $error("row read counter overran");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_DONE)
        else $error("result produced outside the done state");
`endif

endmodule

>>> tb/life_cellular_automaton_test.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_test
// Self-checking bench for the B3/S23 cell grid. A queue-fed driver offers
// write, advance, read and unused ops while a bit-plane model of the grid predicts
// each reply; a monitor compares every reply transfer against the oldest
// prediction. Runs through many area sizes, wrap modes and random stalls.
// ----------------------------------------------------------------------------
module life_cellular_automaton_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lca_pkg::*;

    localparam int unsigned GRID_MAX      = 64;
    localparam int unsigned QUIET_LIMIT   = 20000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 16;

    typedef struct packed {
        t_op         op;
        logic [5:0]  col;
        logic [5:0]  row;
        logic        val;
        logic [15:0] gens;
    } t_cell_op;

    typedef struct packed {
        logic alive;
        logic oor;
    } t_cell_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_index            cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    t_cell_op              in_item = '0;
    logic                  out_stall = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_alive;
    logic                  o_out_of_range;

    t_cell_op    op_q [$];
    t_cell_reply reply_q [$];

    logic [63:0] cell_grid [GRID_MAX];
    logic [63:0] next_grid [GRID_MAX];
    logic [6:0]  width_reg = 7'd64;
    logic [6:0]  height_reg = 7'd64;
    logic        wrap_reg = 1'b0;

    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    bit          calm = 1'b0;

    life_cellular_automaton #(
        .MAX_WIDTH  (GRID_MAX),
        .MAX_HEIGHT (GRID_MAX)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (in_item.op),
        .i_col          (in_item.col),
        .i_row          (in_item.row),
        .i_cell_value   (in_item.val),
        .i_generations  (in_item.gens),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_alive        (o_alive),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned used_size(logic [6:0] v);
        if (v == 7'd0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return 32'(v);
    endfunction

    // out[c] = in[c-1]
    function automatic logic [63:0] from_west(logic [63:0] r, int w, bit wrap,
                                              logic [63:0] mask);
        logic [63:0] s;
        s = (r << 1) & mask;
        if (wrap) s[0] = s[0] | r[w-1];
        return s;
    endfunction

    // out[c] = in[c+1]
    function automatic logic [63:0] from_east(logic [63:0] r, int w, bit wrap);
        logic [63:0] s;
        s = r >> 1;
        if (wrap) s[w-1] = s[w-1] | r[0];
        return s;
    endfunction

    function automatic bit life_generation(int w, int h, bit wrap);
        logic [63:0] mask, above, mid, below;
        logic [63:0] sum0, sum1, sum2, sum3, carry, carry2, low, born, stay;
        logic [63:0] nbr [8];
        int          ya, yb;
        bit          changed;
        logic [63:0] upd;
        changed = 1'b0;
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        for (int y = 0; y < h; y++) begin
            ya = (y == 0) ? (wrap ? h - 1 : -1) : y - 1;
            yb = (y + 1 == h) ? (wrap ? 0 : -1) : y + 1;
            above = (ya < 0) ? '0 : (cell_grid[ya] & mask);
            mid = cell_grid[y] & mask;
            below = (yb < 0) ? '0 : (cell_grid[yb] & mask);
            nbr[0] = above;
            nbr[1] = from_west(above, w, wrap, mask);
            nbr[2] = from_east(above, w, wrap);
            nbr[3] = below;
            nbr[4] = from_west(below, w, wrap, mask);
            nbr[5] = from_east(below, w, wrap);
            nbr[6] = from_west(mid, w, wrap, mask);
            nbr[7] = from_east(mid, w, wrap);
            sum0 = '0;
            sum1 = '0;
            sum2 = '0;
            sum3 = '0;
            // per-cell neighbour count as four bit planes
            for (int i = 0; i < 8; i++) begin
                carry = sum0 & nbr[i];
                sum0 = sum0 ^ nbr[i];
                carry2 = sum1 & carry;
                sum1 = sum1 ^ carry;
                carry = sum2 & carry2;
                sum2 = sum2 ^ carry2;
                sum3 = sum3 ^ carry;
            end
            low = ~sum2 & ~sum3;
            born = sum0 & sum1 & low;
            stay = ~sum0 & sum1 & low;
            next_grid[y] = (born | (mid & stay)) & mask;
        end
        for (int y = 0; y < h; y++) begin
            upd = (cell_grid[y] & ~mask) | next_grid[y];
            if (upd != cell_grid[y]) changed = 1'b1;
            cell_grid[y] = upd;
        end
        return changed;
    endfunction

    function automatic t_cell_reply predict_reply(t_cell_op it);
        t_cell_reply rep;
        int          w, h;
        int unsigned g;
        rep = '0;
        w = used_size(width_reg);
        h = used_size(height_reg);
        case (it.op)
            OP_WRITE, OP_READ: begin
                if (it.col >= w || it.row >= h) begin
                    rep.oor = 1'b1;
                end else if (it.op == OP_WRITE) begin
                    cell_grid[it.row][it.col] = it.val;
                end else begin
                    rep.alive = cell_grid[it.row][it.col];
                end
            end
            OP_ADVANCE: begin
                g = 0;
                while (g < it.gens && life_generation(w, h, wrap_reg)) g++;
            end
            default: ;
        endcase
        return rep;
    endfunction

    function automatic bit roll_idle();
        return !calm && ($urandom_range(99) < 34);
    endfunction

    task automatic log_failure(string what);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) reply_q.push_back(predict_reply(in_item));
            if (!in_valid || !o_in_stall) begin
                if (op_q.size() != 0 && !roll_idle()) begin
                    in_item <= op_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= roll_idle();
        end
    end

    // reply check
    always @(posedge i_clk) begin : reply_check
        t_cell_reply want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (reply_q.size() == 0) begin
                log_failure($sformatf("unexpected transfer alive=%0b out_of_range=%0b",
                                      o_alive, o_out_of_range));
            end else begin
                want = reply_q.pop_front();
                if (o_alive !== want.alive || o_out_of_range !== want.oor)
                    log_failure($sformatf("alive exp %0b got %0b, out_of_range exp %0b got %0b",
                                          want.alive, o_alive, want.oor, o_out_of_range));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("life_cellular_automaton_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_op(t_op op, int unsigned col, int unsigned row, bit val,
                           int unsigned gens);
        t_cell_op it;
        it.op = op;
        it.col = col[5:0];
        it.row = row[5:0];
        it.val = val;
        it.gens = gens[15:0];
        op_q.push_back(it);
    endtask

    task automatic write_reg(t_cfg_index idx, int unsigned value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[6:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  width_reg = value[6:0];
            CFG_GRID_HEIGHT: height_reg = value[6:0];
            CFG_WRAP_EDGES:  wrap_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (op_q.size() != 0 || in_valid || reply_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_coord(int unsigned size);
        return ($urandom_range(99) < 85) ? $urandom_range(size - 1) : $urandom_range(63);
    endfunction

    // a lone cell on a 1x1 area settles within two generations
    function automatic int unsigned pick_gens(int unsigned w, int unsigned h);
        int unsigned r;
        if (w == 1 && h == 1 && $urandom_range(99) < 30) return $urandom_range(65535);
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(3);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(40, 13);
    endfunction

    task automatic random_ops(int unsigned count);
        int unsigned made, w, h, c0, r0, n;
        t_op         kind;
        made = 0;
        w = used_size(width_reg);
        h = used_size(height_reg);
        while (made < count) begin
            if ($urandom_range(99) < 75) begin
                // seed a 3x3 patch, evolve it, then read a 4x4 block over it and the row above and column left of it
                c0 = pick_coord(w);
                r0 = pick_coord(h);
                for (int i = 0; i < 9; i++)
                    push_op(OP_WRITE, (c0 + i % 3) % 64, (r0 + i / 3) % 64,
                            1'($urandom_range(1)), $urandom_range(65535));
                push_op(OP_ADVANCE, $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)), pick_gens(w, h));
                for (int i = 0; i < 16; i++)
                    push_op(OP_READ, (c0 + 63 + i % 4) % 64, (r0 + 63 + i / 4) % 64,
                            1'($urandom_range(1)), $urandom_range(65535));
                made += 26;
            end else begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) begin
                    kind = t_op'($urandom_range(3));
                    push_op(kind, pick_coord(w), pick_coord(h), 1'($urandom_range(1)),
                            (kind == OP_ADVANCE) ? pick_gens(w, h) : $urandom_range(65535));
                end
                made += n;
            end
        end
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, bit wrap, int unsigned count,
                             bit hold, bit quiet);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_WRAP_EDGES, 32'(wrap));
        calm = quiet;
        if (hold) hold_asked++;
        random_ops(count);
        drain();
        calm = 1'b0;
    endtask

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return $urandom_range(4, 1);
        if (r < 30) return ($urandom_range(1) != 0) ? 0 : $urandom_range(127, 65);
        return $urandom_range(64, 5);
    endfunction

    initial begin
        foreach (cell_grid[r]) cell_grid[r] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset grid, corners, big advance on empty grid, blinker
        push_op(OP_READ, 0, 0, 1'b0, 0);
        push_op(OP_READ, 63, 63, 1'b0, 0);
        push_op(OP_ADVANCE, 0, 0, 1'b0, 65535);
        push_op(OP_WRITE, 0, 0, 1'b1, 65535);
        push_op(OP_WRITE, 63, 63, 1'b1, 0);
        push_op(OP_READ, 0, 0, 1'b0, 0);
        push_op(OP_READ, 63, 63, 1'b0, 0);
        push_op(OP_WRITE, 10, 20, 1'b1, 0);
        push_op(OP_WRITE, 11, 20, 1'b1, 0);
        push_op(OP_WRITE, 12, 20, 1'b1, 0);
        push_op(OP_ADVANCE, 63, 63, 1'b1, 1);
        push_op(OP_READ, 11, 19, 1'b0, 0);
        push_op(OP_READ, 10, 20, 1'b0, 0);
        push_op(OP_ADVANCE, 0, 0, 1'b0, 0);
        push_op(OP_READ, 11, 21, 1'b0, 0);
        push_op(OP_NONE, 63, 63, 1'b1, 65535);
        push_op(OP_WRITE, 0, 0, 1'b0, 0);
        push_op(OP_READ, 0, 0, 1'b0, 0);
        drain();

        // directed: one-cell torus and coordinates off the area
        write_reg(CFG_GRID_WIDTH, 1);
        write_reg(CFG_GRID_HEIGHT, 1);
        write_reg(CFG_WRAP_EDGES, 1);
        push_op(OP_WRITE, 0, 0, 1'b1, 0);
        push_op(OP_ADVANCE, 0, 0, 1'b0, 65535);
        push_op(OP_READ, 0, 0, 1'b0, 0);
        push_op(OP_WRITE, 1, 0, 1'b1, 0);
        push_op(OP_READ, 0, 1, 1'b0, 0);
        drain();

        run_phase(64, 64, 0, 150, 1'b1, 1'b0);
        run_phase(64, 64, 1, 130, 1'b0, 1'b0);
        run_phase(1, 1, 0, 100, 1'b0, 1'b0);
        run_phase(2, 2, 1, 100, 1'b0, 1'b0);
        run_phase(3, 3, 1, 120, 1'b0, 1'b1);
        run_phase(0, 5, 1, 100, 1'b0, 1'b0);
        run_phase(127, 127, 0, 150, 1'b0, 1'b0);
        run_phase(17, 9, 1, 130, 1'b0, 1'b0);
        run_phase(8, 64, 0, 120, 1'b0, 1'b0);
        run_phase(64, 3, 1, 120, 1'b0, 1'b0);
        run_phase(64, 64, 0, 130, 1'b1, 1'b0);
        repeat (4) run_phase(pick_size(), pick_size(), 1'($urandom_range(1)), 110, 1'b0,
                             1'b0);

        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && reply_q.size() == 0) begin
            $display("life_cellular_automaton_test passed");
        end else begin
            $display("life_cellular_automaton_test failed");
        end
        $finish;
    end

endmodule
